[rtl/pol_pkg.sv]
package pol_pkg;

    localparam int CAPACITY = 16;
    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 3;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND    = 3'd0,
        OP_PREPEND   = 3'd1,
        OP_INSERT    = 3'd2,
        OP_READ_OUT  = 3'd3,
        OP_UPDATE    = 3'd4,
        OP_DEL_FIRST = 3'd5,
        OP_DEL_LAST  = 3'd6,
        OP_DEL_POS   = 3'd7
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 3'd0,
        ST_BADPOS = 3'd1,
        ST_FULL   = 3'd2,
        ST_NODEL  = 3'd3,
        ST_ELEM   = 3'd4,
        ST_EMPTY  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_READ
    } state_t;

    typedef struct packed {
        logic                    valid;
        status_t                 status;
        logic signed [VAL_W-1:0] element;
        logic                    last;
    } result_t;

endpackage

[rtl/pol_mem.sv]
module pol_mem #(
    parameter int DEPTH = pol_pkg::CAPACITY,
    parameter int WIDTH = pol_pkg::VAL_W,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/pol_seq.sv]
module pol_seq #(
    parameter int CAPACITY = pol_pkg::CAPACITY,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [pol_pkg::OP_W-1:0]         op,
    input  logic [pol_pkg::POS_W-1:0]        position,
    input  logic signed [pol_pkg::VAL_W-1:0] value,
    output logic                             busy,
    output pol_pkg::result_t                 res,
    output logic                             mem_we,
    output logic [AW-1:0]                    mem_waddr,
    output logic [pol_pkg::VAL_W-1:0]        mem_wdata,
    output logic                             mem_re,
    output logic [AW-1:0]                    mem_raddr,
    input  logic [pol_pkg::VAL_W-1:0]        mem_rdata
);

    pol_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [pol_pkg::VAL_W-1:0] val_reg, val_next;

    // Checks against the current fill.
    logic [7:0] pos_w;
    logic [7:0] cnt_w;
    logic       full;
    logic       empty;
    logic       ins_ok;
    logic       upd_ok;
    logic [pol_pkg::POS_W-1:0] pos_m1;
    logic [AW-1:0] pos_idx;
    logic [CW-1:0] cnt_m1;
    logic [AW-1:0] cnt_lo;
    logic [AW-1:0] cnt_m1_lo;
    logic [CW-1:0] cur_p1;
    logic [CW:0]   cur_p2;
    logic [AW-1:0] cur_m2;
    logic          up_end;
    logic          dn_end;
    logic          rd_end;

    // Decode of the accepted command.
    pol_pkg::op_t     opc;
    logic             d_imm;
    pol_pkg::status_t d_status;
    logic             d_write;
    logic [AW-1:0]    d_tgt;
    logic             d_inc;
    logic             d_dec;
    logic             d_up;
    logic             d_dn;
    logic             d_rd;

    assign pos_w     = {1'b0, position};
    assign cnt_w     = 8'(count_reg);
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign ins_ok    = (position != '0) && (pos_w <= (cnt_w + 8'd1));
    assign upd_ok    = (position != '0) && (pos_w <= cnt_w);
    assign pos_m1    = position - 7'd1;
    assign pos_idx   = pos_m1[AW-1:0];
    assign cnt_m1    = count_reg - CW'(1);
    assign cnt_lo    = count_reg[AW-1:0];
    assign cnt_m1_lo = cnt_m1[AW-1:0];
    assign cur_p1    = CW'(cur_reg) + CW'(1);
    assign cur_p2    = (CW+1)'(cur_reg) + (CW+1)'(2);
    assign cur_m2    = cur_reg - AW'(2);
    assign up_end    = (cur_reg == idx_reg);
    assign dn_end    = !(cur_p2 < {1'b0, count_reg});
    assign rd_end    = (cur_p1 == count_reg);
    assign busy      = (state_reg != pol_pkg::S_IDLE);
    assign opc       = pol_pkg::op_t'(op);

    always_comb
    begin
        d_imm    = 1'b0;
        d_status = pol_pkg::ST_OK;
        d_write  = 1'b0;
        d_tgt    = '0;
        d_inc    = 1'b0;
        d_dec    = 1'b0;
        d_up     = 1'b0;
        d_dn     = 1'b0;
        d_rd     = 1'b0;
        case (opc)
            pol_pkg::OP_APPEND, pol_pkg::OP_PREPEND, pol_pkg::OP_INSERT:
            begin
                if (full)
                begin
                    d_imm    = 1'b1;
                    d_status = pol_pkg::ST_FULL;
                end
                else if ((opc == pol_pkg::OP_INSERT) && !ins_ok)
                begin
                    d_imm    = 1'b1;
                    d_status = pol_pkg::ST_BADPOS;
                end
                else
                begin
                    if (opc == pol_pkg::OP_APPEND)
                    begin
                        d_tgt = cnt_lo;
                    end
                    else if (opc == pol_pkg::OP_PREPEND)
                    begin
                        d_tgt = '0;
                    end
                    else
                    begin
                        d_tgt = pos_idx;
                    end
                    if (CW'(d_tgt) == count_reg)
                    begin
                        d_imm   = 1'b1;
                        d_write = 1'b1;
                        d_inc   = 1'b1;
                    end
                    else
                    begin
                        d_up = 1'b1;
                    end
                end
            end
            pol_pkg::OP_READ_OUT:
            begin
                if (empty)
                begin
                    d_imm    = 1'b1;
                    d_status = pol_pkg::ST_EMPTY;
                end
                else
                begin
                    d_rd = 1'b1;
                end
            end
            pol_pkg::OP_UPDATE:
            begin
                d_imm = 1'b1;
                if (!upd_ok)
                begin
                    d_status = pol_pkg::ST_BADPOS;
                end
                else
                begin
                    d_write = 1'b1;
                    d_tgt   = pos_idx;
                end
            end
            pol_pkg::OP_DEL_FIRST, pol_pkg::OP_DEL_LAST, pol_pkg::OP_DEL_POS:
            begin
                if ((opc == pol_pkg::OP_DEL_POS) && !upd_ok)
                begin
                    d_imm    = 1'b1;
                    d_status = pol_pkg::ST_BADPOS;
                end
                else if (empty)
                begin
                    d_imm    = 1'b1;
                    d_status = pol_pkg::ST_NODEL;
                end
                else
                begin
                    if (opc == pol_pkg::OP_DEL_FIRST)
                    begin
                        d_tgt = '0;
                    end
                    else if (opc == pol_pkg::OP_DEL_LAST)
                    begin
                        d_tgt = cnt_m1_lo;
                    end
                    else
                    begin
                        d_tgt = pos_idx;
                    end
                    if ((CW'(d_tgt) + CW'(1)) == count_reg)
                    begin
                        d_imm = 1'b1;
                        d_dec = 1'b1;
                    end
                    else
                    begin
                        d_dn = 1'b1;
                    end
                end
            end
            default:
            begin
                d_imm    = 1'b1;
                d_status = pol_pkg::ST_BADPOS;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pol_pkg::S_IDLE:
            begin
                if (start && d_up)
                begin
                    state_next = pol_pkg::S_SHIFT_UP;
                end
                else if (start && d_dn)
                begin
                    state_next = pol_pkg::S_SHIFT_DN;
                end
                else if (start && d_rd)
                begin
                    state_next = pol_pkg::S_READ;
                end
            end
            pol_pkg::S_SHIFT_UP:
            begin
                if (up_end)
                begin
                    state_next = pol_pkg::S_IDLE;
                end
            end
            pol_pkg::S_SHIFT_DN:
            begin
                if (dn_end)
                begin
                    state_next = pol_pkg::S_IDLE;
                end
            end
            pol_pkg::S_READ:
            begin
                if (rd_end)
                begin
                    state_next = pol_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pol_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next  = count_reg;
        cur_next    = cur_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        mem_we      = 1'b0;
        mem_waddr   = cur_reg;
        mem_wdata   = mem_rdata;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        res.valid   = 1'b0;
        res.status  = pol_pkg::ST_OK;
        res.element = '0;
        res.last    = 1'b0;
        case (state_reg)
            pol_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (d_imm)
                    begin
                        res.valid  = 1'b1;
                        res.status = d_status;
                        res.last   = 1'b1;
                    end
                    if (d_write)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = d_tgt;
                        mem_wdata = value;
                    end
                    if (d_inc)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    if (d_dec)
                    begin
                        count_next = cnt_m1;
                    end
                    if (d_up)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = cnt_m1_lo;
                        cur_next  = cnt_lo;
                        idx_next  = d_tgt;
                        val_next  = value;
                    end
                    if (d_dn)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = d_tgt + AW'(1);
                        cur_next  = d_tgt;
                    end
                    if (d_rd)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                        cur_next  = '0;
                    end
                end
            end
            pol_pkg::S_SHIFT_UP:
            begin
                mem_we = 1'b1;
                if (up_end)
                begin
                    mem_wdata  = val_reg;
                    count_next = count_reg + CW'(1);
                    res.valid  = 1'b1;
                    res.last   = 1'b1;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = cur_m2;
                    cur_next  = cur_reg - AW'(1);
                end
            end
            pol_pkg::S_SHIFT_DN:
            begin
                mem_we = 1'b1;
                if (dn_end)
                begin
                    count_next = cnt_m1;
                    res.valid  = 1'b1;
                    res.last   = 1'b1;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = cur_p2[AW-1:0];
                    cur_next  = cur_reg + AW'(1);
                end
            end
            pol_pkg::S_READ:
            begin
                res.valid   = 1'b1;
                res.status  = pol_pkg::ST_ELEM;
                res.element = mem_rdata;
                res.last    = rd_end;
                if (!rd_end)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = cur_p1[AW-1:0];
                    cur_next  = cur_reg + AW'(1);
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pol_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        idx_reg <= idx_next;
        val_reg <= val_next;
    end

endmodule

[rtl/positional_ordered_list_core.sv]
// Channel   Direction  Handshake                  Beat contents
// command   in         start & !busy              op, position, value
// result    out        result_valid (no stall)    status, element, last
//
// Update, append, an insert or delete at the tail end of the list, and any
// command that fails its checks never raise busy; the result beat follows
// in the next cycle. An insert that must move entries keeps busy high until
// it has moved them, a delete that must move entries likewise, and a
// read-out until its last element beat, with one element beat per cycle.
// The sweeps are paced by the single list memory, which gives one read and
// one write per cycle, so entries are moved one at a time.
// Reset clears the fill count; the memory itself is not cleared, and no
// entry beyond the fill count is ever returned. The receiver cannot stall.
module positional_ordered_list_core #(
    parameter int CAPACITY = pol_pkg::CAPACITY,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [pol_pkg::OP_W-1:0]          op,
    input  logic [pol_pkg::POS_W-1:0]         position,
    input  logic signed [pol_pkg::VAL_W-1:0]  value,
    output logic                              result_valid,
    output logic [pol_pkg::STAT_W-1:0]        status,
    output logic signed [pol_pkg::VAL_W-1:0]  element,
    output logic                              last
);

    // Sequencer outputs toward the list memory.
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [pol_pkg::VAL_W-1:0] mem_wdata;
    logic                      mem_re;
    logic [AW-1:0]             mem_raddr;
    logic [pol_pkg::VAL_W-1:0] mem_rdata;

    // The result beat decided this cycle and the register that presents it.
    pol_pkg::result_t res;
    pol_pkg::result_t res_reg;

    // The sequencer owns the fill count and the shift and read-out sweeps.
    // Each shift sweep reads one entry while writing back a different one (a
    // read-out only reads), so a write never lands on the address being read in
    // the same cycle, and busy holds off new commands until the sweep is done.
    pol_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .op        (op),
        .position  (position),
        .value     (value),
        .busy      (busy),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // List storage: position p of the list sits at address p - 1.
    pol_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (pol_pkg::VAL_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The whole beat register is reset, so no stale payload shows after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg <= res;
        end
    end

    assign result_valid = res_reg.valid;
    assign status       = res_reg.status;
    assign element      = res_reg.element;
    assign last         = res_reg.last;

    // An accepted command either answers in the next cycle or starts a sweep.
    a_accept_progress : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (result_valid || busy))
        else $error("accepted command neither answered nor started a sweep");

    // A beat that is not the final one belongs to a read-out still running.
    a_nonlast_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> busy)
        else $error("non-final beat while the sequencer is idle");

    // Only element beats can come in a group; every other status ends it.
    a_status_last : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status != pol_pkg::ST_ELEM)) |-> (last && (element == '0)))
        else $error("status beat not final or carries an element");

    // While a sweep runs, no beat other than read-out elements appears early.
    a_sweep_quiet : assert property (@(posedge clk) disable iff (!rst_n)
        (busy && $past(busy) && result_valid) |-> (status == pol_pkg::ST_ELEM))
        else $error("status beat while a sweep is in progress");

endmodule

[tb/tb.sv]
// Self-checking bench for positional_ordered_list_core.
module tb;

    // Longest run of cycles in which neither a command nor a result beat is
    // accepted before the run is declared hung. The slowest legal gap is an
    // insert at the head of a list one entry short of full or a long random
    // sender pause, both far below this.
    localparam int STALL_LIMIT = 4000;

    // Cycles allowed after the last expected beat for stray beats to appear.
    localparam int DRAIN_CYCLES = 4 * pol_pkg::CAPACITY;

    // Items in each of the three random phases.
    localparam int PHASE_ITEMS = 106;

    // One result beat as the list should produce it.
    typedef struct {
        pol_pkg::status_t                 status;
        logic signed [pol_pkg::VAL_W-1:0] element;
        logic                             last;
    } beat_t;

    logic                             clk;
    logic                             rst_n;
    logic                             start;
    logic                             busy;
    logic [pol_pkg::OP_W-1:0]         op;
    logic [pol_pkg::POS_W-1:0]        position;
    logic signed [pol_pkg::VAL_W-1:0] value;
    logic                             result_valid;
    logic [pol_pkg::STAT_W-1:0]       status;
    logic signed [pol_pkg::VAL_W-1:0] element;
    logic                             last;

    // Shadow copy of the list contents; index 0 is list position 1.
    logic signed [pol_pkg::VAL_W-1:0] list_shadow[$];

    // Result beats that the block still owes, oldest first.
    beat_t pending_beats[$];

    int sender_idle_pct;
    int error_count;
    int stall_cycles;
    int commands_taken;
    int beats_checked;
    int full_refusals;
    int position_refusals;
    int peak_fill;

    positional_ordered_list_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .position     (position),
        .value        (value),
        .result_valid (result_valid),
        .status       (status),
        .element      (element),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Queue one single-beat status result.
    function automatic void owe_status(pol_pkg::status_t st);
        beat_t b;
        b.status  = st;
        b.element = '0;
        b.last    = 1'b1;
        pending_beats.push_back(b);
        if (st == pol_pkg::ST_FULL)
            full_refusals++;
        if (st == pol_pkg::ST_BADPOS)
            position_refusals++;
    endfunction

    // Apply one accepted command to the shadow list and queue the beats it
    // must produce. Positions are 1-based; inserts accept one past the end,
    // updates and deletes only existing entries. The full check on an insert
    // at a position wins over the position check.
    function automatic void predict_command(pol_pkg::op_t cmd,
                                            logic [pol_pkg::POS_W-1:0] pos,
                                            logic signed [pol_pkg::VAL_W-1:0] val);
        int    fill;
        int    p;
        beat_t b;
        fill = list_shadow.size();
        p    = int'(pos);
        case (cmd)
            pol_pkg::OP_APPEND:
                if (fill >= pol_pkg::CAPACITY)
                    owe_status(pol_pkg::ST_FULL);
                else
                begin
                    list_shadow.push_back(val);
                    owe_status(pol_pkg::ST_OK);
                end
            pol_pkg::OP_PREPEND:
                if (fill >= pol_pkg::CAPACITY)
                    owe_status(pol_pkg::ST_FULL);
                else
                begin
                    list_shadow.push_front(val);
                    owe_status(pol_pkg::ST_OK);
                end
            pol_pkg::OP_INSERT:
                if (fill >= pol_pkg::CAPACITY)
                    owe_status(pol_pkg::ST_FULL);
                else if (p < 1 || p > fill + 1)
                    owe_status(pol_pkg::ST_BADPOS);
                else
                begin
                    list_shadow.insert(p - 1, val);
                    owe_status(pol_pkg::ST_OK);
                end
            pol_pkg::OP_READ_OUT:
                if (fill == 0)
                begin
                    b.status  = pol_pkg::ST_EMPTY;
                    b.element = '0;
                    b.last    = 1'b1;
                    pending_beats.push_back(b);
                end
                else
                begin
                    for (int k = 0; k < fill; k++)
                    begin
                        b.status  = pol_pkg::ST_ELEM;
                        b.element = list_shadow[k];
                        b.last    = (k == fill - 1);
                        pending_beats.push_back(b);
                    end
                end
            pol_pkg::OP_UPDATE:
                if (p < 1 || p > fill)
                    owe_status(pol_pkg::ST_BADPOS);
                else
                begin
                    list_shadow[p - 1] = val;
                    owe_status(pol_pkg::ST_OK);
                end
            pol_pkg::OP_DEL_FIRST:
                if (fill == 0)
                    owe_status(pol_pkg::ST_NODEL);
                else
                begin
                    void'(list_shadow.pop_front());
                    owe_status(pol_pkg::ST_OK);
                end
            pol_pkg::OP_DEL_LAST:
                if (fill == 0)
                    owe_status(pol_pkg::ST_NODEL);
                else
                begin
                    void'(list_shadow.pop_back());
                    owe_status(pol_pkg::ST_OK);
                end
            default:
                if (p < 1 || p > fill)
                    owe_status(pol_pkg::ST_BADPOS);
                else
                begin
                    list_shadow.delete(p - 1);
                    owe_status(pol_pkg::ST_OK);
                end
        endcase
        if (list_shadow.size() > peak_fill)
            peak_fill = list_shadow.size();
    endfunction

    // Compare one result beat against the oldest owed beat, field by field.
    task automatic check_beat();
        beat_t want;
        if (pending_beats.size() == 0)
        begin
            $display("%0t: stray beat, expected none, actual status %0d element %0d last %0d",
                     $time, status, element, last);
            error_count++;
        end
        else
        begin
            want = pending_beats.pop_front();
            beats_checked++;
            if (status !== want.status)
            begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, status);
                error_count++;
            end
            if (element !== want.element)
            begin
                $display("%0t: element mismatch, expected %0d, actual %0d",
                         $time, want.element, element);
                error_count++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last mismatch, expected %0d, actual %0d",
                         $time, want.last, last);
                error_count++;
            end
        end
    endtask

    // Monitor. Result beats are checked before a command taken on the same
    // edge is predicted, so a new command can never satisfy an older beat.
    // Everything here reads values from before the edge.
    always @(posedge clk)
    begin
        if (result_valid === 1'b1)
            check_beat();
        if (start && busy === 1'b0)
        begin
            predict_command(pol_pkg::op_t'(op), position, value);
            commands_taken++;
        end
        if (result_valid === 1'b1 || (start && busy === 1'b0))
            stall_cycles = 0;
        else
            stall_cycles++;
    end

    // Watchdog: ends the run if the block stops moving.
    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // Send one command beat. Called and returning at a falling edge. The
    // sender may first pause for a random number of cycles; start then stays
    // high with the fields held until the block takes the beat. On return,
    // start is still high, so a back-to-back command simply replaces the
    // fields at the same falling edge.
    task automatic send_command(pol_pkg::op_t cmd, logic [pol_pkg::POS_W-1:0] pos,
                                logic signed [pol_pkg::VAL_W-1:0] val);
        bit taken;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start    = 1'b1;
        op       = cmd;
        position = pos;
        value    = val;
        do
        begin
            @(posedge clk);
            taken = (busy === 1'b0);
            @(negedge clk);
        end
        while (!taken);
    endtask

    // Data values lean toward the sign and range boundaries.
    function automatic logic signed [pol_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Positions are mostly legal or one step outside, sometimes zero, and
    // sometimes anywhere in the 7-bit field.
    function automatic logic [pol_pkg::POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(9);
        if (r < 7)
            return pol_pkg::POS_W'($urandom_range(list_shadow.size() + 1, 1));
        else if (r == 7)
            return '0;
        else
            return pol_pkg::POS_W'($urandom_range(127));
    endfunction

    // Growing mode favors inserts so the list reaches capacity; draining
    // mode favors deletes so it empties again. A few picks are plain noise.
    function automatic pol_pkg::op_t pick_op(bit growing);
        int r;
        r = $urandom_range(99);
        if (r >= 95)
            return pol_pkg::op_t'($urandom_range(7));
        if (growing)
        begin
            if (r < 25) return pol_pkg::OP_APPEND;
            if (r < 40) return pol_pkg::OP_PREPEND;
            if (r < 64) return pol_pkg::OP_INSERT;
            if (r < 72) return pol_pkg::OP_READ_OUT;
            if (r < 82) return pol_pkg::OP_UPDATE;
            if (r < 86) return pol_pkg::OP_DEL_FIRST;
            if (r < 90) return pol_pkg::OP_DEL_LAST;
            return pol_pkg::OP_DEL_POS;
        end
        if (r < 8)  return pol_pkg::OP_APPEND;
        if (r < 14) return pol_pkg::OP_PREPEND;
        if (r < 22) return pol_pkg::OP_INSERT;
        if (r < 32) return pol_pkg::OP_READ_OUT;
        if (r < 42) return pol_pkg::OP_UPDATE;
        if (r < 60) return pol_pkg::OP_DEL_FIRST;
        if (r < 78) return pol_pkg::OP_DEL_LAST;
        return pol_pkg::OP_DEL_POS;
    endfunction

    // Everything that can be asked of an empty list: read-out gives the
    // single empty beat, the head and tail deletes report nothing deleted,
    // and every positional access is out of range.
    task automatic test_empty_list();
        send_command(pol_pkg::OP_READ_OUT, 7'd0, '0);
        send_command(pol_pkg::OP_DEL_FIRST, 7'd0, '0);
        send_command(pol_pkg::OP_DEL_LAST, 7'd0, '0);
        send_command(pol_pkg::OP_DEL_POS, 7'd1, '0);
        send_command(pol_pkg::OP_UPDATE, 7'd1, 32'sh1234_5678);
        send_command(pol_pkg::OP_INSERT, 7'd0, 32'sh1111_1111);
        send_command(pol_pkg::OP_INSERT, 7'd2, 32'sh2222_2222);
    endtask

    // Position bounds on a small list, with the extreme data values, and a
    // read-out of several entries.
    task automatic test_positions();
        send_command(pol_pkg::OP_INSERT, 7'd1, 32'sh7FFF_FFFF);
        send_command(pol_pkg::OP_PREPEND, 7'd0, 32'sh8000_0000);
        send_command(pol_pkg::OP_APPEND, 7'd0, '0);
        send_command(pol_pkg::OP_INSERT, 7'd4, -32'sd1);
        send_command(pol_pkg::OP_INSERT, 7'd6, 32'sh0BAD_0BAD);
        send_command(pol_pkg::OP_UPDATE, 7'd4, 32'sh5A5A_A5A5);
        send_command(pol_pkg::OP_UPDATE, 7'd5, 32'sh3C3C_3C3C);
        send_command(pol_pkg::OP_DEL_POS, 7'd5, '0);
        send_command(pol_pkg::OP_DEL_POS, 7'd2, '0);
        send_command(pol_pkg::OP_READ_OUT, 7'd0, '0);
        send_command(pol_pkg::OP_DEL_FIRST, 7'd0, '0);
        send_command(pol_pkg::OP_DEL_LAST, 7'd0, '0);
    endtask

    // Fill to capacity, then every kind of insert is refused, the insert at
    // a bad position included, since the full check comes first.
    task automatic test_full_list();
        while (list_shadow.size() < pol_pkg::CAPACITY)
            send_command(pol_pkg::OP_APPEND, 7'd0, pick_value());
        send_command(pol_pkg::OP_APPEND, 7'd0, 32'sh0F0F_0F0F);
        send_command(pol_pkg::OP_PREPEND, 7'd0, 32'sh0F0F_0F0F);
        send_command(pol_pkg::OP_INSERT, 7'd0, 32'sh0F0F_0F0F);
        send_command(pol_pkg::OP_INSERT, 7'd3, 32'sh0F0F_0F0F);
        send_command(pol_pkg::OP_READ_OUT, 7'd0, '0);
        send_command(pol_pkg::OP_DEL_POS, 7'd127, '0);
        send_command(pol_pkg::OP_DEL_POS, pol_pkg::POS_W'(pol_pkg::CAPACITY), '0);
    endtask

    // Random commands in alternating growing and draining stretches, so the
    // list keeps swinging between empty and full.
    task automatic test_random(int items, int idle_pct);
        pol_pkg::op_t cmd;
        sender_idle_pct = idle_pct;
        for (int i = 0; i < items; i++)
        begin
            cmd = pick_op(((i / 24) % 2) == 0);
            send_command(cmd, pick_position(), pick_value());
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        start             = 1'b0;
        op                = pol_pkg::OP_APPEND;
        position          = '0;
        value             = '0;
        sender_idle_pct   = 0;
        error_count       = 0;
        stall_cycles      = 0;
        commands_taken    = 0;
        beats_checked     = 0;
        full_refusals     = 0;
        position_refusals = 0;
        peak_fill         = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        sender_idle_pct = 7;
        test_empty_list();
        test_positions();
        test_full_list();

        test_random(PHASE_ITEMS, 7);
        test_random(PHASE_ITEMS, 74);
        test_random(PHASE_ITEMS, 0);
        start = 1'b0;

        // Let every owed beat arrive, then watch a while longer for strays.
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d commands, checked %0d beats; fill peaked at %0d of %0d.",
                 commands_taken, beats_checked, peak_fill, pol_pkg::CAPACITY);
        $display("Inserts refused when full: %0d, commands refused for position: %0d.",
                 full_refusals, position_refusals);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
